// ===== rtl/sfd_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sfd_pkg
// Shared types and constants of the sync frame deframer: configuration
// layout, register indexes, item codes and the result record that travels
// from the parser through the result queue to the output stage.
// ============================================================================
package sfd_pkg;

    // Result queue geometry.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Configuration port layout.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_SYNC_FIRST    = 2'd0;
    localparam cfg_index_t CFG_SYNC_SECOND   = 2'd1;
    localparam cfg_index_t CFG_TIMEOUT_TICKS = 2'd2;
    localparam cfg_index_t CFG_MAX_LENGTH    = 2'd3;

    // Configuration reset values.
    localparam logic [7:0]  SYNC_FIRST_RST  = 8'hB5;
    localparam logic [7:0]  SYNC_SECOND_RST = 8'h62;
    localparam logic [15:0] TIMEOUT_RST     = 16'd10000;
    localparam logic [15:0] MAX_LENGTH_RST  = 16'd256;

    // Tick counter saturates at its all-ones value.
    localparam int          TICK_W   = 17;
    localparam logic [16:0] TICK_MAX = 17'h1FFFF;

    // Input item kinds.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Result kinds.
    localparam logic RESULT_PAYLOAD = 1'b0;
    localparam logic RESULT_FRAME   = 1'b1;

    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [15:0] timeout_ticks;
        logic [15:0] max_payload_length;
    } cfg_t;

    // One request for the output side; the checksum comparison and the
    // length check are finished in the output stage.
    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic [15:0] msg_id;
        logic [15:0] frame_length;
        logic [7:0]  ck_lo;
        logic [7:0]  ck_hi;
        logic [7:0]  sum_a;
        logic [7:0]  sum_b;
    } rec_t;

endpackage

// ===== rtl/sfd_parser.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sfd_parser
// Front end: accepts one byte or tick per cycle while accept is high, tracks the frame phase,
// the Fletcher-8 sums and the hunt timeout, and hands result requests to
// the result queue.
// ============================================================================
module sfd_parser
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic          kind,
    input  logic [7:0]    rx_byte,
    input  sfd_pkg::cfg_t cfg,
    output logic          rec_valid,
    output sfd_pkg::rec_t rec
);

    typedef enum logic [3:0] {
        PH_SYNC1   = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_CLASS   = 4'd2,
        PH_ID      = 4'd3,
        PH_LEN_LO  = 4'd4,
        PH_LEN_HI  = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CK_LO   = 4'd7,
        PH_CK_HI   = 4'd8
    } phase_t;

    phase_t      phase_reg, phase_next, phase_eff;
    logic [15:0] msg_id_reg, msg_id_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] index_reg, index_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [7:0]  ck_lo_reg, ck_lo_next;
    logic [sfd_pkg::TICK_W-1:0] ticks_reg, ticks_next;

    logic [7:0]  sum_a_add;
    logic [7:0]  sum_b_add;
    logic [15:0] index_inc;
    logic [15:0] length_full;

    // Fletcher-8 update with the current byte.
    assign sum_a_add   = sum_a_reg + rx_byte;
    assign sum_b_add   = sum_b_reg + sum_a_add;
    assign index_inc   = index_reg + 16'd1;
    assign length_full = {rx_byte, length_reg[7:0]};

    // A byte seen after too many ticks is handled as a hunt byte.
    always_comb
    begin
        if (ticks_reg > {1'b0, cfg.timeout_ticks})
        begin
            phase_eff = PH_SYNC1;
        end
        else
        begin
            phase_eff = phase_reg;
        end
    end

    // Next-state logic and result request.
    always_comb
    begin
        phase_next  = phase_reg;
        msg_id_next = msg_id_reg;
        length_next = length_reg;
        index_next  = index_reg;
        sum_a_next  = sum_a_reg;
        sum_b_next  = sum_b_reg;
        ck_lo_next  = ck_lo_reg;
        ticks_next  = ticks_reg;
        rec_valid   = 1'b0;
        rec         = '0;

        if (accept)
        begin
            if (kind == sfd_pkg::KIND_TICK)
            begin
                if (ticks_reg != sfd_pkg::TICK_MAX)
                begin
                    ticks_next = ticks_reg + 17'd1;
                end
            end
            else
            begin
                phase_next = phase_eff;
                unique case (phase_eff)
                    PH_SYNC2:
                    begin
                        phase_next = (rx_byte == cfg.sync_second) ? PH_CLASS : PH_SYNC1;
                        sum_a_next = 8'd0;
                        sum_b_next = 8'd0;
                    end
                    PH_CLASS:
                    begin
                        msg_id_next = {8'd0, rx_byte};
                        sum_a_next  = sum_a_add;
                        sum_b_next  = sum_b_add;
                        phase_next  = PH_ID;
                    end
                    PH_ID:
                    begin
                        msg_id_next = {rx_byte, msg_id_reg[7:0]};
                        sum_a_next  = sum_a_add;
                        sum_b_next  = sum_b_add;
                        phase_next  = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        length_next = {8'd0, rx_byte};
                        sum_a_next  = sum_a_add;
                        sum_b_next  = sum_b_add;
                        phase_next  = PH_LEN_HI;
                    end
                    PH_LEN_HI:
                    begin
                        length_next = length_full;
                        sum_a_next  = sum_a_add;
                        sum_b_next  = sum_b_add;
                        index_next  = 16'd0;
                        phase_next  = (length_full != 16'd0) ? PH_PAYLOAD : PH_CK_LO;
                    end
                    PH_PAYLOAD:
                    begin
                        sum_a_next        = sum_a_add;
                        sum_b_next        = sum_b_add;
                        rec_valid         = 1'b1;
                        rec.kind          = sfd_pkg::RESULT_PAYLOAD;
                        rec.payload_byte  = rx_byte;
                        rec.byte_index    = index_reg;
                        rec.msg_id        = msg_id_reg;
                        rec.frame_length  = length_reg;
                        index_next        = index_inc;
                        if (index_inc == length_reg)
                        begin
                            phase_next = PH_CK_LO;
                        end
                    end
                    PH_CK_LO:
                    begin
                        ck_lo_next = rx_byte;
                        phase_next = PH_CK_HI;
                    end
                    PH_CK_HI:
                    begin
                        rec_valid        = 1'b1;
                        rec.kind         = sfd_pkg::RESULT_FRAME;
                        rec.msg_id       = msg_id_reg;
                        rec.frame_length = length_reg;
                        rec.ck_lo        = ck_lo_reg;
                        rec.ck_hi        = rx_byte;
                        rec.sum_a        = sum_a_reg;
                        rec.sum_b        = sum_b_reg;
                        phase_next       = PH_SYNC1;
                    end
                    default:
                    begin
                        // Hunting for the first sync byte.
                        phase_next = (rx_byte == cfg.sync_first) ? PH_SYNC2 : PH_SYNC1;
                        ticks_next = '0;
                    end
                endcase
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SYNC1;
            msg_id_reg <= '0;
            length_reg <= '0;
            index_reg  <= '0;
            sum_a_reg  <= '0;
            sum_b_reg  <= '0;
            ck_lo_reg  <= '0;
            ticks_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            msg_id_reg <= msg_id_next;
            length_reg <= length_next;
            index_reg  <= index_next;
            sum_a_reg  <= sum_a_next;
            sum_b_reg  <= sum_b_next;
            ck_lo_reg  <= ck_lo_next;
            ticks_reg  <= ticks_next;
        end
    end

    // A tick never moves the frame phase.
    a_tick_holds_phase: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (kind == sfd_pkg::KIND_TICK) |=> $stable(phase_reg))
        else $error("tick changed the parse phase");

    // Inside the payload the byte index stays below the declared length.
    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (index_reg < length_reg))
        else $error("payload index beyond declared length");

endmodule

// ===== rtl/sfd_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sfd_queue
// Short result queue between the parser and the output stage, so that the
// front keeps taking items while the back is stalled, until the queue is full.
// ============================================================================
module sfd_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  sfd_pkg::rec_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output logic          rd_valid,
    output sfd_pkg::rec_t rd_data
);

    sfd_pkg::rec_t entry_reg [sfd_pkg::QUEUE_DEPTH];

    logic [sfd_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [sfd_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [sfd_pkg::QUEUE_CNT_W-1:0] count_reg;
    logic                            do_wr;
    logic                            do_rd;

    assign full     = (count_reg == sfd_pkg::QUEUE_CNT_W'(sfd_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    // Storage for waiting requests.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sfd_pkg::QUEUE_CNT_W'(sfd_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    // Pointer distance agrees with the fill count.
    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[sfd_pkg::QUEUE_PTR_W-1:0])
        else $error("result queue pointers disagree with count");

endmodule

// ===== rtl/sfd_output.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sfd_output
// Back end: takes requests from the result queue, finishes the checksum
// comparison and the length check, and holds the result for the consumer.
// ============================================================================
module sfd_output
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  sfd_pkg::rec_t q_data,
    output logic          q_rd,
    input  logic [15:0]   max_payload_length,
    input  logic          pop,
    output logic          empty,
    output logic          result_kind,
    output logic [7:0]    payload_byte,
    output logic [15:0]   byte_index,
    output logic [15:0]   msg_id,
    output logic [15:0]   frame_length,
    output logic          checksum_ok,
    output logic          too_long
);

    logic        valid_reg;
    logic        kind_reg;
    logic [7:0]  byte_reg;
    logic [15:0] index_reg;
    logic [15:0] msg_id_reg;
    logic [15:0] length_reg;
    logic        ck_ok_reg;
    logic        too_long_reg;
    logic        is_frame;

    // Load a new request when the output register is free or being drained.
    assign q_rd     = q_valid && (!valid_reg || pop);
    assign is_frame = (q_data.kind == sfd_pkg::RESULT_FRAME);

    // Valid flag of the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (q_rd)
        begin
            valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Result payload, with the frame checks finished on load.
    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            kind_reg     <= q_data.kind;
            byte_reg     <= q_data.payload_byte;
            index_reg    <= q_data.byte_index;
            msg_id_reg   <= q_data.msg_id;
            length_reg   <= q_data.frame_length;
            ck_ok_reg    <= is_frame && (q_data.ck_lo == q_data.sum_a)
                                     && (q_data.ck_hi == q_data.sum_b);
            too_long_reg <= is_frame && (q_data.frame_length > max_payload_length);
        end
    end

    assign empty        = !valid_reg;
    assign result_kind  = kind_reg;
    assign payload_byte = byte_reg;
    assign byte_index   = index_reg;
    assign msg_id       = msg_id_reg;
    assign frame_length = length_reg;
    assign checksum_ok  = ck_ok_reg;
    assign too_long     = too_long_reg;

    // Frame flags appear only on frame results.
    a_flags_frame_only: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && (kind_reg == sfd_pkg::RESULT_PAYLOAD) |-> !ck_ok_reg && !too_long_reg)
        else $error("frame flag set on a payload result");

endmodule

// ===== rtl/sync_frame_deframer_fletcher8_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sync_frame_deframer_fletcher8_top
// Frame deframer with Fletcher-8 checksum: hunts two sync bytes, reads id,
// length, payload and checksum, emits payload bytes and one frame result.
// ============================================================================
//
//  Channel   Handshake            Fields
//  -------   ------------------   ----------------------------------------------
//  input     push / full          kind, rx_byte
//  result    empty / pop          result_kind, payload_byte, byte_index, msg_id,
//                                 frame_length, checksum_ok, too_long
//  config    cfg_we               cfg_index, cfg_data
//
//  One byte or tick is taken every cycle while full is low. A result
//  goes from the parser into the result queue and from there into the
//  output register, which drives the ports.
//  Reset clears the parser, the queue and the output register and loads the
//  register defaults; there is no clearing pass.
//  full rises when the four-entry result queue holds four requests; with the
//  output register that is five results waiting before input stalls.
//
module sync_frame_deframer_fletcher8_top
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        kind,
    input  logic [7:0]                  rx_byte,
    output logic                        empty,
    input  logic                        pop,
    output logic                        result_kind,
    output logic [7:0]                  payload_byte,
    output logic [15:0]                 byte_index,
    output logic [15:0]                 msg_id,
    output logic [15:0]                 frame_length,
    output logic                        checksum_ok,
    output logic                        too_long,
    input  logic                        cfg_we,
    input  sfd_pkg::cfg_index_t         cfg_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0] cfg_data
);

    sfd_pkg::cfg_t cfg_reg;
    sfd_pkg::rec_t rec;
    sfd_pkg::rec_t q_data;
    logic          rec_valid;
    logic          q_valid;
    logic          q_rd;
    logic          accept;

    assign accept = push && !full;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first         <= sfd_pkg::SYNC_FIRST_RST;
            cfg_reg.sync_second        <= sfd_pkg::SYNC_SECOND_RST;
            cfg_reg.timeout_ticks      <= sfd_pkg::TIMEOUT_RST;
            cfg_reg.max_payload_length <= sfd_pkg::MAX_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sfd_pkg::CFG_SYNC_FIRST:    cfg_reg.sync_first         <= cfg_data[7:0];
                sfd_pkg::CFG_SYNC_SECOND:   cfg_reg.sync_second        <= cfg_data[7:0];
                sfd_pkg::CFG_TIMEOUT_TICKS: cfg_reg.timeout_ticks      <= cfg_data;
                sfd_pkg::CFG_MAX_LENGTH:    cfg_reg.max_payload_length <= cfg_data;
                default:                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Front end: frame parser.
    sfd_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .kind      (kind),
        .rx_byte   (rx_byte),
        .cfg       (cfg_reg),
        .rec_valid (rec_valid),
        .rec       (rec)
    );

    // Result queue between front and back.
    sfd_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (rec_valid),
        .wr_data  (rec),
        .full     (full),
        .rd_en    (q_rd),
        .rd_valid (q_valid),
        .rd_data  (q_data)
    );

    // Back end: result checks and output register.
    sfd_output u_output
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .q_valid            (q_valid),
        .q_data             (q_data),
        .q_rd               (q_rd),
        .max_payload_length (cfg_reg.max_payload_length),
        .pop                (pop),
        .empty              (empty),
        .result_kind        (result_kind),
        .payload_byte       (payload_byte),
        .byte_index         (byte_index),
        .msg_id             (msg_id),
        .frame_length       (frame_length),
        .checksum_ok        (checksum_ok),
        .too_long           (too_long)
    );

endmodule

// ===== verif/sync_frame_deframer_fletcher8_top_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sync_frame_deframer_fletcher8_top_tb
// Self-checking bench for the sync frame deframer. Bytes and ticks are pushed
// into the block, and a cycle-free model of the parser predicts every payload
// byte and frame result. Results are popped and compared in order. Traffic is
// mostly well-formed frames with random content, mixed with noise, ticks,
// broken sync pairs and cut-off frames, under several register settings.
// ============================================================================
module sync_frame_deframer_fletcher8_top_tb;

    localparam int CLK_HALF_NS   = 2;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int RUN_LIMIT_NS  = 4_000_000;
    localparam int WHOLE_FRAME   = 1 << 30;
    localparam int REPORT_LIMIT  = 10;

    typedef enum logic [3:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_CLASS,
        PH_ID,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_PAYLOAD,
        PH_CK_LO,
        PH_CK_HI
    } parse_phase_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic [15:0] msg_id;
        logic [15:0] frame_length;
        logic        checksum_ok;
        logic        too_long;
    } deframe_result_t;

    // Parser model with its own register copy and the queue of results
    // still owed by the block.
    class deframe_tracker;
        logic [7:0]        sync_a;
        logic [7:0]        sync_b;
        logic [15:0]       timeout_lim;
        logic [15:0]       max_len;

        parse_phase_t      phase;
        logic [15:0]       left_bytes;
        logic [15:0]       decl_len;
        logic [15:0]       cur_id;
        logic [7:0]        fl_a;
        logic [7:0]        fl_b;
        logic [7:0]        ck_lo;
        logic [sfd_pkg::TICK_W-1:0] idle_ticks;

        deframe_result_t   expected_results[$];
        int                failures;
        int                payloads_seen;
        int                frames_seen;
        int                good_frames;
        int                long_frames;

        function new();
            sync_a      = sfd_pkg::SYNC_FIRST_RST;
            sync_b      = sfd_pkg::SYNC_SECOND_RST;
            timeout_lim = sfd_pkg::TIMEOUT_RST;
            max_len     = sfd_pkg::MAX_LENGTH_RST;
            phase       = PH_SYNC1;
            left_bytes  = '0;
            decl_len    = '0;
            cur_id      = '0;
            fl_a        = '0;
            fl_b        = '0;
            ck_lo       = '0;
            idle_ticks  = '0;
            failures    = 0;
            payloads_seen = 0;
            frames_seen = 0;
            good_frames = 0;
            long_frames = 0;
        endfunction

        function void note_failure(string what);
            failures++;
            if (failures <= REPORT_LIMIT)
            begin
                $display("[%0t] MISMATCH: %s", $realtime, what);
            end
        endfunction

        function void set_reg(sfd_pkg::cfg_index_t idx, logic [15:0] value);
            case (idx)
                sfd_pkg::CFG_SYNC_FIRST:    sync_a      = value[7:0];
                sfd_pkg::CFG_SYNC_SECOND:   sync_b      = value[7:0];
                sfd_pkg::CFG_TIMEOUT_TICKS: timeout_lim = value;
                sfd_pkg::CFG_MAX_LENGTH:    max_len     = value;
                default: ;
            endcase
        endfunction

        function void add_to_sum(logic [7:0] b);
            fl_a = fl_a + b;
            fl_b = fl_b + fl_a;
        endfunction

        // Advance the parser by one accepted request.
        function void accept_item(logic k, logic [7:0] b);
            deframe_result_t r;
            if (k == sfd_pkg::KIND_TICK)
            begin
                if (idle_ticks != sfd_pkg::TICK_MAX)
                begin
                    idle_ticks++;
                end
                return;
            end

            // Too many ticks since the last hunt byte: start over.
            if (idle_ticks > {1'b0, timeout_lim})
            begin
                phase      = PH_SYNC1;
                left_bytes = '0;
            end

            case (phase)
                PH_SYNC2:
                begin
                    phase = (b == sync_b) ? PH_CLASS : PH_SYNC1;
                    fl_a  = '0;
                    fl_b  = '0;
                end
                PH_CLASS:
                begin
                    cur_id = {8'h00, b};
                    add_to_sum(b);
                    phase = PH_ID;
                end
                PH_ID:
                begin
                    cur_id[15:8] = b;
                    add_to_sum(b);
                    phase = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    decl_len = {8'h00, b};
                    add_to_sum(b);
                    phase = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    decl_len[15:8] = b;
                    add_to_sum(b);
                    left_bytes = decl_len;
                    phase = (decl_len != 16'd0) ? PH_PAYLOAD : PH_CK_LO;
                end
                PH_PAYLOAD:
                begin
                    add_to_sum(b);
                    r = '0;
                    r.kind         = sfd_pkg::RESULT_PAYLOAD;
                    r.payload_byte = b;
                    r.byte_index   = decl_len - left_bytes;
                    r.msg_id       = cur_id;
                    r.frame_length = decl_len;
                    expected_results.push_back(r);
                    left_bytes = left_bytes - 16'd1;
                    if (left_bytes == 16'd0)
                    begin
                        phase = PH_CK_LO;
                    end
                end
                PH_CK_LO:
                begin
                    ck_lo = b;
                    phase = PH_CK_HI;
                end
                PH_CK_HI:
                begin
                    r = '0;
                    r.kind         = sfd_pkg::RESULT_FRAME;
                    r.msg_id       = cur_id;
                    r.frame_length = decl_len;
                    r.checksum_ok  = (ck_lo == fl_a) && (b == fl_b);
                    r.too_long     = (decl_len > max_len);
                    expected_results.push_back(r);
                    phase = PH_SYNC1;
                end
                default:
                begin
                    phase      = (b == sync_a) ? PH_SYNC2 : PH_SYNC1;
                    idle_ticks = '0;
                end
            endcase
        endfunction

        // Compare one popped result with the oldest one owed.
        function void match_result(deframe_result_t got);
            deframe_result_t want;
            if (expected_results.size() == 0)
            begin
                note_failure($sformatf("unexpected result kind=%0d byte=%02h idx=%0d id=%04h",
                                       got.kind, got.payload_byte, got.byte_index,
                                       got.msg_id));
                return;
            end
            want = expected_results.pop_front();
            if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
                got.byte_index !== want.byte_index || got.msg_id !== want.msg_id ||
                got.frame_length !== want.frame_length ||
                got.checksum_ok !== want.checksum_ok || got.too_long !== want.too_long)
            begin
                note_failure($sformatf(
                    "exp kind=%0d byte=%02h idx=%0d id=%04h len=%0d ok=%0d long=%0d, got %0d %02h %0d %04h %0d %0d %0d",
                    want.kind, want.payload_byte, want.byte_index, want.msg_id,
                    want.frame_length, want.checksum_ok, want.too_long,
                    got.kind, got.payload_byte, got.byte_index, got.msg_id,
                    got.frame_length, got.checksum_ok, got.too_long));
            end
            if (want.kind == sfd_pkg::RESULT_FRAME)
            begin
                frames_seen++;
                if (want.checksum_ok)
                begin
                    good_frames++;
                end
                if (want.too_long)
                begin
                    long_frames++;
                end
            end
            else
            begin
                payloads_seen++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        kind;
    logic [7:0]  rx_byte;
    logic        empty;
    logic        pop;
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic [15:0] msg_id;
    logic [15:0] frame_length;
    logic        checksum_ok;
    logic        too_long;
    logic        cfg_we;
    sfd_pkg::cfg_index_t cfg_index;
    logic [sfd_pkg::CFG_DATA_W-1:0] cfg_data;

    deframe_tracker tracker;
    int send_idle;
    int take_idle;
    int items_sent;

    sync_frame_deframer_fletcher8_top dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .kind         (kind),
        .rx_byte      (rx_byte),
        .empty        (empty),
        .pop          (pop),
        .result_kind  (result_kind),
        .payload_byte (payload_byte),
        .byte_index   (byte_index),
        .msg_id       (msg_id),
        .frame_length (frame_length),
        .checksum_ok  (checksum_ok),
        .too_long     (too_long),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF_NS) clk = ~clk;
    end

    // Overall run limit.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("end of test: mismatches");
        $finish;
    end

    // Receiver: pop at random, as often as the current setting allows.
    always @(negedge clk)
    begin
        pop <= rst_n && ($urandom_range(99) >= take_idle);
    end

    // Watch both handshakes at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                tracker.accept_item(kind, rx_byte);
            end
            if (pop && !empty)
            begin
                tracker.match_result('{result_kind, payload_byte, byte_index, msg_id,
                                       frame_length, checksum_ok, too_long});
            end
        end
    end

    // Offer one request and hold it until it is taken; starts and ends at
    // a falling edge.
    task automatic send_item(logic k, logic [7:0] b);
        while ($urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push    <= 1'b1;
        kind    <= k;
        rx_byte <= b;
        do @(posedge clk); while (full);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_item(sfd_pkg::KIND_TICK, 8'($urandom));
    endtask

    // Build a frame with the current sync bytes and send up to cut bytes of
    // it, with optional ticks slipped in between bytes.
    task automatic send_frame(logic [15:0] id, logic [15:0] len, bit bad_ck, int fill,
                              int cut, int tick_pct);
        logic [7:0] frame_bytes[$];
        logic [7:0] sa;
        logic [7:0] sb;
        int         n;
        int         pos;
        frame_bytes = {};
        sa = '0;
        sb = '0;
        frame_bytes.push_back(tracker.sync_a);
        frame_bytes.push_back(tracker.sync_b);
        frame_bytes.push_back(id[7:0]);
        frame_bytes.push_back(id[15:8]);
        frame_bytes.push_back(len[7:0]);
        frame_bytes.push_back(len[15:8]);
        for (n = 0; n < int'(len) && frame_bytes.size() < cut; n++)
        begin
            frame_bytes.push_back((fill < 0) ? 8'($urandom) : fill[7:0]);
        end
        for (n = 2; n < frame_bytes.size(); n++)
        begin
            sa = sa + frame_bytes[n];
            sb = sb + sa;
        end
        frame_bytes.push_back(sa);
        frame_bytes.push_back(sb);
        if (bad_ck)
        begin
            pos = frame_bytes.size() - 1 - $urandom_range(1);
            frame_bytes[pos] = frame_bytes[pos] ^ 8'(1 << $urandom_range(7));
        end
        for (n = 0; n < frame_bytes.size() && n < cut; n++)
        begin
            if (tick_pct > 0 && $urandom_range(99) < tick_pct)
            begin
                send_ticks($urandom_range(1, 3));
            end
            send_item(sfd_pkg::KIND_BYTE, frame_bytes[n]);
        end
    endtask

    // Stop offering input and let the block empty out.
    task automatic wait_quiet();
        int waited;
        waited = 0;
        push <= 1'b0;
        while (tracker.expected_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (tracker.expected_results.size() != 0)
        begin
            tracker.note_failure($sformatf("%0d results never arrived",
                                           tracker.expected_results.size()));
            tracker.expected_results.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write all four registers, one per cycle; the block must be idle.
    task automatic load_config(logic [7:0] s1, logic [7:0] s2, logic [15:0] tmo,
                               logic [15:0] mx);
        sfd_pkg::cfg_index_t idx_list[4];
        logic [15:0]         val_list[4];
        idx_list = '{sfd_pkg::CFG_SYNC_FIRST, sfd_pkg::CFG_SYNC_SECOND,
                     sfd_pkg::CFG_TIMEOUT_TICKS, sfd_pkg::CFG_MAX_LENGTH};
        val_list = '{{8'h00, s1}, {8'h00, s2}, tmo, mx};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx_list[i];
            cfg_data  <= val_list[i];
            @(negedge clk);
            tracker.set_reg(idx_list[i], val_list[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // Random traffic: mostly good frames, plus noise, tick bursts, broken
    // sync pairs and frames cut short.
    task automatic run_traffic(int n);
        int          start;
        int          pick;
        int          lsel;
        int          hi;
        logic [15:0] len;
        start = items_sent;
        while (items_sent - start < n)
        begin
            pick = $urandom_range(99);
            lsel = $urandom_range(99);
            if (lsel < 50)
                len = 16'($urandom_range(0, 4));
            else if (lsel < 85)
                len = 16'($urandom_range(5, 16));
            else if (lsel < 97)
                len = 16'($urandom_range(17, 40));
            else if (tracker.max_len < 16'd300)
                len = tracker.max_len + 16'($urandom_range(1, 3));
            else
                len = 16'($urandom_range(41, 64));

            if (pick < 65)
            begin
                send_frame(16'($urandom), len, ($urandom_range(4) == 0), -1, WHOLE_FRAME,
                           ($urandom_range(3) == 0) ? 15 : 0);
            end
            else if (pick < 75)
            begin
                repeat ($urandom_range(1, 6)) send_item(sfd_pkg::KIND_BYTE, 8'($urandom));
            end
            else if (pick < 85)
            begin
                hi = (tracker.timeout_lim < 16'd40) ? int'(tracker.timeout_lim) + 3 : 5;
                send_ticks($urandom_range(0, hi));
            end
            else if (pick < 92)
            begin
                send_item(sfd_pkg::KIND_BYTE, tracker.sync_a);
                send_item(sfd_pkg::KIND_BYTE, tracker.sync_b ^ 8'($urandom_range(1, 255)));
            end
            else
            begin
                send_frame(16'($urandom), len, 1'b0, -1,
                           6 + $urandom_range(0, int'(len) + 1), 0);
            end
        end
    endtask

    // Main sequence.
    initial
    begin
        rst_n      = 1'b0;
        push       = 1'b0;
        kind       = sfd_pkg::KIND_BYTE;
        rx_byte    = '0;
        cfg_we     = 1'b0;
        cfg_index  = sfd_pkg::CFG_SYNC_FIRST;
        cfg_data   = '0;
        send_idle  = 17;
        take_idle  = 48;
        items_sent = 0;
        tracker    = new();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: zero length, all-ones id with a bad checksum, a second
        // sync byte that does not match and is not taken as a first one.
        send_frame(16'h0000, 16'd0, 1'b0, -1, WHOLE_FRAME, 0);
        send_frame(16'hFFFF, 16'd2, 1'b1, 8'hFF, WHOLE_FRAME, 0);
        send_item(sfd_pkg::KIND_BYTE, sfd_pkg::SYNC_FIRST_RST);
        send_item(sfd_pkg::KIND_BYTE, sfd_pkg::SYNC_FIRST_RST);
        send_item(sfd_pkg::KIND_BYTE, sfd_pkg::SYNC_SECOND_RST);
        send_frame(16'h0A01, 16'd1, 1'b0, 8'h00, WHOLE_FRAME, 0);
        wait_quiet();

        // Directed with no tick allowance: a frame declaring the largest
        // length is abandoned by one tick, then a short frame is too long.
        load_config(sfd_pkg::SYNC_FIRST_RST, sfd_pkg::SYNC_SECOND_RST, 16'd0, 16'd0);
        send_frame(16'h8001, 16'hFFFF, 1'b0, -1, 8, 0);
        send_ticks(1);
        send_frame(16'h1234, 16'd1, 1'b0, -1, WHOLE_FRAME, 0);
        wait_quiet();

        load_config(sfd_pkg::SYNC_FIRST_RST, sfd_pkg::SYNC_SECOND_RST,
                    sfd_pkg::TIMEOUT_RST, sfd_pkg::MAX_LENGTH_RST);
        run_traffic(260);
        wait_quiet();

        send_idle = 48;
        take_idle = 17;
        load_config(8'h00, 8'hFF, 16'd6, 16'd0);
        run_traffic(260);
        wait_quiet();

        send_idle = 0;
        take_idle = 0;
        load_config(8'hFF, 8'h00, 16'hFFFF, 16'hFFFF);
        run_traffic(140);
        wait_quiet();

        load_config(8'($urandom), 8'($urandom), 16'($urandom_range(3, 40)),
                    16'($urandom_range(0, 12)));
        run_traffic(140);
        wait_quiet();

        $display("Sent %0d bytes and ticks under six register settings.", items_sent);
        $display("Checked %0d payload bytes and %0d frames (%0d good checksum, %0d too long).",
                 tracker.payloads_seen, tracker.frames_seen, tracker.good_frames,
                 tracker.long_frames);
        if (tracker.failures == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sfd_pkg.sv
rtl/sfd_parser.sv
rtl/sfd_queue.sv
rtl/sfd_output.sv
rtl/sync_frame_deframer_fletcher8_top.sv
verif/sync_frame_deframer_fletcher8_top_tb.sv
